// ===== rtl/lmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lmbs_pkg
// Shared types and constants of the label map boundary shader.
// ----------------------------------------------------------------------------
package lmbs_pkg;

  localparam int unsigned CfgDataBits  = 13;
  localparam int unsigned CfgIndexBits = 8;
  localparam int unsigned LabelPortBits = 16;
  localparam int unsigned RowBits      = 13;

  // register indexes of the configuration port
  localparam logic [CfgIndexBits-1:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [CfgIndexBits-1:0] CFG_FRAME_HEIGHT = 8'd1;

  localparam logic [RowBits-1:0] RESET_HEIGHT = 13'd4096;

  localparam logic [7:0] SHADE_EDGE   = 8'd60;
  localparam logic [7:0] SHADE_FILL_RG = 8'd218;
  localparam logic [7:0] SHADE_FILL_B = 8'd210;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  localparam logic [31:0] COLOR_EMPTY = 32'h0000_0000;
  localparam logic [31:0] COLOR_EDGE  = {ALPHA_OPAQUE, SHADE_EDGE, SHADE_EDGE, SHADE_EDGE};
  localparam logic [31:0] COLOR_FILL  = {ALPHA_OPAQUE, SHADE_FILL_RG, SHADE_FILL_RG,
                                         SHADE_FILL_B};

  // per-item neighbor qualifiers, set at issue and used one stage later
  typedef struct packed {
    logic has_out;    // item lies below the first row and yields a result
    logic use_up;     // row above the output row is inside the frame
    logic use_left;   // left neighbor inside the frame
    logic use_right;  // right neighbor inside the frame
    logic frame_end;  // bottom-right pixel of the frame
  } item_flags_t;

  function automatic logic [31:0] shade_color(input logic in_region, input logic is_edge);
    logic [31:0] c;
    if (!in_region) begin
      c = COLOR_EMPTY;
    end else if (is_edge) begin
      c = COLOR_EDGE;
    end else begin
      c = COLOR_FILL;
    end
    return c;
  endfunction

endpackage

// ===== rtl/label_map_boundary_shader_unit.sv =====
// ----------------------------------------------------------------------------
// label_map_boundary_shader_unit
// 4-neighbor boundary shading of a raster label stream, one row late.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while the output is not stalled, set by the single
//   write port of each line buffer; once the pixel below it is accepted, the result for
//   a pixel passes the line buffer read register and then the output register
// reset: position registers clear and geometry returns to 4096 x 4096 at once; the line
//   buffers are not cleared and get filled by the first rows of each frame
module label_map_boundary_shader_unit import lmbs_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned LABEL_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0]   cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic [LabelPortBits-1:0] label_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [31:0]              color_o,
  output logic                     is_boundary_o,
  output logic                     in_region_o,
  output logic                     frame_end_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned LW = (LABEL_BITS < LabelPortBits) ? LABEL_BITS : LabelPortBits;

  logic              issue;
  logic [AW-1:0]     iss_x, iss_x_prev, iss_x_next;
  logic [LW-1:0]     iss_label;
  item_flags_t       iss_flags;

  logic [LW-1:0]     up_a, up_b, mid_a, mid_b;

  // stage 1: item whose line buffer reads are in flight
  logic              s1_valid_q;
  logic [AW-1:0]     s1_x_q;
  logic [LW-1:0]     s1_label_q;
  item_flags_t       s1_flags_q;
  logic              fwd_up_a_q, fwd_up_b_q, fwd_mid_a_q, fwd_mid_b_q;
  logic [LW-1:0]     fwd_up_q, fwd_mid_q;

  logic              s1_adv;
  logic              s1_fire;
  logic [LW-1:0]     center, up, left, right;
  logic              in_region, is_edge;

  logic              out_valid_q;
  logic [31:0]       color_q;
  logic              is_boundary_q, in_region_q, frame_end_q;

  assign cfg_ready_o = 1'b1;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign s1_fire    = s1_valid_q && s1_adv;

  lmbs_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .LW        (LW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .cmd_i       (cmd_i),
    .label_i     (label_i),
    .issue_o     (issue),
    .x_o         (iss_x),
    .x_prev_o    (iss_x_prev),
    .x_next_o    (iss_x_next),
    .label_o     (iss_label),
    .flags_o     (iss_flags)
  );

  // row above the output row; written with the center label as it retires
  lmbs_line_buf #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (LW)
  ) u_upper (
    .clk_i     (clk_i),
    .we_i      (s1_fire),
    .waddr_i   (s1_x_q),
    .wdata_i   (center),
    .re_i      (issue),
    .raddr_a_i (iss_x),
    .raddr_b_i (iss_x_prev),
    .rdata_a_o (up_a),
    .rdata_b_o (up_b)
  );

  // output row; written with the incoming label
  lmbs_line_buf #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (LW)
  ) u_middle (
    .clk_i     (clk_i),
    .we_i      (s1_fire),
    .waddr_i   (s1_x_q),
    .wdata_i   (s1_label_q),
    .re_i      (issue),
    .raddr_a_i (iss_x),
    .raddr_b_i (iss_x_next),
    .rdata_a_o (mid_a),
    .rdata_b_o (mid_b)
  );

  // a read issued in the same cycle as a write to that entry sees old data
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_x_q      <= iss_x;
      s1_label_q  <= iss_label;
      s1_flags_q  <= iss_flags;
      fwd_up_a_q  <= s1_fire && (s1_x_q == iss_x);
      fwd_up_b_q  <= s1_fire && (s1_x_q == iss_x_prev);
      fwd_mid_a_q <= s1_fire && (s1_x_q == iss_x);
      fwd_mid_b_q <= s1_fire && (s1_x_q == iss_x_next);
      fwd_up_q    <= center;
      fwd_mid_q   <= s1_label_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (issue) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_comb begin
    center = fwd_mid_a_q ? fwd_mid_q : mid_a;
    up     = !s1_flags_q.use_up    ? '0 : (fwd_up_a_q  ? fwd_up_q  : up_a);
    left   = !s1_flags_q.use_left  ? '0 : (fwd_up_b_q  ? fwd_up_q  : up_b);
    right  = !s1_flags_q.use_right ? '0 : (fwd_mid_b_q ? fwd_mid_q : mid_b);
    in_region = (center != '0);
    is_edge   = in_region && ((left != center) || (right != center) ||
                              (up != center) || (s1_label_q != center));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q && s1_flags_q.has_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_flags_q.has_out) begin
      color_q       <= shade_color(in_region, is_edge);
      is_boundary_q <= is_edge;
      in_region_q   <= in_region;
      frame_end_q   <= s1_flags_q.frame_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_o       = color_q;
  assign is_boundary_o = is_boundary_q;
  assign in_region_o   = in_region_q;
  assign frame_end_o   = frame_end_q;

  // a boundary pixel always belongs to a region
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!is_boundary_o || in_region_o))
    else $error("boundary flagged outside a region");

  // pixels outside any region are transparent black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_region_o) |-> (color_o == COLOR_EMPTY))
    else $error("empty pixel with nonzero color");

  // input back-pressure only comes from a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q))
    else $error("input stalled without a held result");

  // a stalled stage 1 item must still be there next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q)
    else $error("stage 1 item lost while stalled");

endmodule

// ===== rtl/lmbs_line_buf.sv =====
// ----------------------------------------------------------------------------
// lmbs_line_buf
// One-row label store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lmbs_line_buf #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/lmbs_scan.sv =====
// ----------------------------------------------------------------------------
// lmbs_scan
// Frame geometry registers and raster position; issues line buffer reads.
// ----------------------------------------------------------------------------
module lmbs_scan import lmbs_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned LW        = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIndexBits-1:0]      cfg_index_i,
  input  logic [CfgDataBits-1:0]       cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         cmd_i,
  input  logic [LabelPortBits-1:0]     label_i,
  output logic                         issue_o,
  output logic [$clog2(MAX_WIDTH)-1:0] x_o,
  output logic [$clog2(MAX_WIDTH)-1:0] x_prev_o,
  output logic [$clog2(MAX_WIDTH)-1:0] x_next_o,
  output logic [LW-1:0]                label_o,
  output item_flags_t                  flags_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned ResetWidth = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam logic [AW-1:0] RESET_WLAST = AW'(ResetWidth - 1);

  logic [AW-1:0]      wlast_q, wlast_d;
  logic [RowBits-1:0] height_q, height_d;
  logic [AW-1:0]      col_q, col_d;
  logic [RowBits-1:0] row_q, row_d;

  logic [31:0]        w_eff;
  logic [AW-1:0]      x;
  logic [RowBits-1:0] r;
  logic               last_col;
  logic               drop;

  // effective width: zero acts as one, clamped to the buffer depth
  always_comb begin
    w_eff = {{(32 - CfgDataBits){1'b0}}, cfg_data_i};
    if (w_eff == 32'd0) begin
      w_eff = 32'd1;
    end
    if (w_eff > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end
  end

  always_comb begin
    wlast_d  = wlast_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH: begin
          wlast_d = AW'(w_eff - 32'd1);
        end
        CFG_FRAME_HEIGHT: begin
          height_d = (cfg_data_i == '0) ? RowBits'(1) : cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    x        = (col_q > wlast_q) ? wlast_q : col_q;
    r        = (row_q > height_q) ? height_q : row_q;
    last_col = (x == wlast_q);
    // surplus flush at the top-left position is swallowed
    drop     = cmd_i && (r == '0) && (x == '0);
    issue_o  = in_valid_i && !in_stall_i && !drop;

    x_o      = x;
    x_prev_o = x - AW'(1);
    x_next_o = x + AW'(1);
    label_o  = (cmd_i || (r == height_q)) ? '0 : label_i[LW-1:0];

    flags_o.has_out   = (r != '0);
    flags_o.use_up    = (r > RowBits'(1));
    flags_o.use_left  = (x != '0);
    flags_o.use_right = !last_col;
    flags_o.frame_end = (r == height_q) && last_col;

    col_d = col_q;
    row_d = row_q;
    if (issue_o) begin
      if (last_col) begin
        col_d = '0;
        row_d = (r >= height_q) ? '0 : r + RowBits'(1);
      end else begin
        col_d = x + AW'(1);
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q  <= RESET_WLAST;
      height_q <= RESET_HEIGHT;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      wlast_q  <= wlast_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule
